// ----- src/vtqr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtqr_pkg: shared types and constants of the vt query responder
// Byte codes, reply selection and the fixed reply byte tables.
// ----------------------------------------------------------------------------
package vtqr_pkg;

    localparam int CAPTURE_SIZE_DEF = 64;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_BRACKET  = 8'h5B;   // '['
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_FINAL_HI = 8'h7E;
    localparam logic [7:0] CH_SIX      = 8'h36;   // '6'
    localparam logic [7:0] CH_FIVE     = 8'h35;   // '5'
    localparam logic [7:0] CH_ZERO     = 8'h30;   // '0'
    localparam logic [7:0] CH_ONE      = 8'h31;   // '1'
    localparam logic [7:0] CH_TWO      = 8'h32;   // '2'
    localparam logic [7:0] CH_GT       = 8'h3E;   // '>'
    localparam logic [7:0] CH_QMARK    = 8'h3F;   // '?'
    localparam logic [7:0] CH_SEMI     = 8'h3B;   // ';'
    localparam logic [7:0] CH_LC_C     = 8'h63;   // 'c'
    localparam logic [7:0] CH_LC_N     = 8'h6E;   // 'n'
    localparam logic [7:0] CH_UC_R     = 8'h52;   // 'R'

    localparam int IDX_W = 4;

    typedef enum logic [1:0] {
        RSP_CPR = 2'd0,    // cursor position report
        RSP_DSR = 2'd1,    // status ok
        RSP_DA1 = 2'd2,    // primary attributes
        RSP_DA2 = 2'd3     // secondary attributes
    } rsp_code_t;

    typedef struct packed {
        logic      valid;
        rsp_code_t code;
    } reply_req_t;

    function automatic logic [IDX_W-1:0] rsp_len(input rsp_code_t code);
        logic [IDX_W-1:0] len;
        case (code)
            RSP_CPR: len = IDX_W'(6);
            RSP_DSR: len = IDX_W'(4);
            RSP_DA1: len = IDX_W'(7);
            RSP_DA2: len = IDX_W'(9);
            default: len = IDX_W'(4);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] rsp_byte(input rsp_code_t code, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = CH_ESC;
        case (idx)
            IDX_W'(0): b = CH_ESC;
            IDX_W'(1): b = CH_BRACKET;
            IDX_W'(2):
            begin
                case (code)
                    RSP_CPR: b = CH_ONE;
                    RSP_DSR: b = CH_ZERO;
                    RSP_DA1: b = CH_QMARK;
                    RSP_DA2: b = CH_GT;
                    default: b = CH_ESC;
                endcase
            end
            IDX_W'(3):
            begin
                case (code)
                    RSP_CPR: b = CH_SEMI;
                    RSP_DSR: b = CH_LC_N;
                    RSP_DA1: b = CH_ONE;
                    RSP_DA2: b = CH_ZERO;
                    default: b = CH_ESC;
                endcase
            end
            IDX_W'(4):
            begin
                case (code)
                    RSP_CPR: b = CH_ONE;
                    RSP_DA1: b = CH_SEMI;
                    RSP_DA2: b = CH_SEMI;
                    default: b = CH_ESC;
                endcase
            end
            IDX_W'(5):
            begin
                case (code)
                    RSP_CPR: b = CH_UC_R;
                    RSP_DA1: b = CH_TWO;
                    RSP_DA2: b = CH_ZERO;
                    default: b = CH_ESC;
                endcase
            end
            IDX_W'(6):
            begin
                case (code)
                    RSP_DA1: b = CH_LC_C;
                    RSP_DA2: b = CH_SEMI;
                    default: b = CH_ESC;
                endcase
            end
            IDX_W'(7): b = CH_ZERO;
            IDX_W'(8): b = CH_LC_C;
            default:   b = CH_ESC;
        endcase
        return b;
    endfunction

endpackage

// ----- src/vtqr_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtqr_parser: escape sequence parser and query matcher
// Tracks normal / escape / csi mode, keeps the capture count and the first
// two captured bytes, and raises a reply request on a recognized query.
// ----------------------------------------------------------------------------
module vtqr_parser
    import vtqr_pkg::*;
#(
    parameter int CAPTURE_SIZE = CAPTURE_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output reply_req_t req
);

    localparam int CNT_W = $clog2(CAPTURE_SIZE);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPTURE_SIZE - 1);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_CSI    = 3'b100
    } mode_t;

    mode_t            mode_reg,   mode_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [7:0]       first_reg,  first_next;
    logic [7:0]       second_reg, second_next;

    logic captured;
    logic is_final;

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        req         = '0;
        captured    = (count_reg != CNT_MAX);
        is_final    = (data_byte >= CH_FINAL_LO) && (data_byte <= CH_FINAL_HI);

        if (accept)
        begin
            case (mode_reg)
                MODE_ESC:
                begin
                    if (data_byte == CH_BRACKET)
                    begin
                        mode_next  = MODE_CSI;
                        count_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_CSI:
                begin
                    if (captured)
                    begin
                        if (count_reg == CNT_W'(0))
                        begin
                            first_next = data_byte;
                        end
                        else if (count_reg == CNT_W'(1))
                        begin
                            second_next = data_byte;
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (is_final)
                    begin
                        mode_next = MODE_NORMAL;
                        // a sequence past the capture limit never matches
                        if (captured)
                        begin
                            if (count_next == CNT_W'(1))
                            begin
                                if (data_byte == CH_LC_C)
                                begin
                                    req = '{valid: 1'b1, code: RSP_DA1};
                                end
                            end
                            else if (count_next == CNT_W'(2))
                            begin
                                if (first_next == CH_SIX && data_byte == CH_LC_N)
                                begin
                                    req = '{valid: 1'b1, code: RSP_CPR};
                                end
                                else if (first_next == CH_FIVE && data_byte == CH_LC_N)
                                begin
                                    req = '{valid: 1'b1, code: RSP_DSR};
                                end
                                else if (first_next == CH_ZERO && data_byte == CH_LC_C)
                                begin
                                    req = '{valid: 1'b1, code: RSP_DA1};
                                end
                                else if (first_next == CH_GT && data_byte == CH_LC_C)
                                begin
                                    req = '{valid: 1'b1, code: RSP_DA2};
                                end
                            end
                            else if (count_next == CNT_W'(3))
                            begin
                                if (first_next == CH_GT && second_next == CH_ZERO
                                    && data_byte == CH_LC_C)
                                begin
                                    req = '{valid: 1'b1, code: RSP_DA2};
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    mode_next = (data_byte == CH_ESC) ? MODE_ESC : MODE_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            count_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // a reply request only ever comes out of csi mode
    a_req_from_csi: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> (accept && mode_reg == MODE_CSI && is_final))
        else $error("reply request outside csi mode");

    // a capture count past the limit is never reached
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_CSI && count_reg == CNT_MAX) |=> (count_reg == CNT_MAX
            || mode_reg != MODE_CSI || $past(mode_reg) == MODE_ESC))
        else $error("capture count wrapped");

    // leaving escape mode always happens on the next accepted byte
    a_esc_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == MODE_ESC) |=> (mode_reg != MODE_ESC))
        else $error("escape mode held after a byte");

endmodule

// ----- src/vtqr_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtqr_emitter: reply sequencer and output register
// Plays out the selected reply one byte per transaction and holds the input
// side until the last byte of a reply is taken.
// ----------------------------------------------------------------------------
module vtqr_emitter
    import vtqr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  reply_req_t req,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] reply_byte,
    output logic       reply_last,
    output logic       in_stall
);

    logic             active_reg, active_next;
    rsp_code_t        code_reg,   code_next;
    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic [7:0]       byte_reg,   byte_next;
    logic             last_reg,   last_next;

    logic out_take;
    logic free;

    assign out_take = active_reg && !out_stall;
    assign free     = !active_reg || (out_take && last_reg);
    assign in_stall = !free;

    assign out_valid  = active_reg;
    assign reply_byte = byte_reg;
    assign reply_last = last_reg;

    always_comb
    begin
        active_next = active_reg;
        code_next   = code_reg;
        idx_next    = idx_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        if (free)
        begin
            active_next = req.valid;
            if (req.valid)
            begin
                code_next = req.code;
                idx_next  = '0;
                byte_next = rsp_byte(req.code, IDX_W'(0));
                last_next = 1'b0;
            end
        end
        else if (out_take)
        begin
            idx_next  = idx_reg + IDX_W'(1);
            byte_next = rsp_byte(code_reg, idx_reg + IDX_W'(1));
            last_next = (idx_reg + IDX_W'(2)) == rsp_len(code_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
    end

    // every reply opens with an escape byte
    a_reply_opens_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && idx_reg == IDX_W'(0)) |-> (byte_reg == CH_ESC))
        else $error("reply does not open with escape");

    // the byte index stays inside the selected reply
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (idx_reg < rsp_len(code_reg)))
        else $error("reply index past reply length");

    // last flag marks exactly the final byte of the reply
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (last_reg == ((idx_reg + IDX_W'(1)) == rsp_len(code_reg))))
        else $error("last flag out of place");

    // no request arrives while a reply is still draining
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> free)
        else $error("reply request while busy");

endmodule

// ----- src/vt_query_responder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt_query_responder_top: terminal query responder
// Watches a terminal output byte stream for device status and device
// attribute queries and emits the fixed reply sequence for each one.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_stall  | data_byte[7:0], chunk_end
//  output   | out_valid / out_stall| reply_byte[7:0], reply_last
//
//  one input byte per cycle while no reply is pending
//  a recognized query starts its reply on the cycle after its final byte
//  a reply of 4 to 9 bytes drains at one byte per cycle while out_stall is low;
//  the input is stalled until the last reply byte is taken, and may be accepted in that same cycle
//  reset clears the parser to normal mode and drops any pending reply
//  chunk_end carries no state: parsing continues across chunks
// ----------------------------------------------------------------------------
module vt_query_responder_top
    import vtqr_pkg::*;
#(
    parameter int CAPTURE_SIZE = CAPTURE_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       chunk_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] reply_byte,
    output logic       reply_last
);

    reply_req_t req;
    logic       accept;

    assign accept = in_valid && !in_stall;

    vtqr_parser #(
        .CAPTURE_SIZE (CAPTURE_SIZE)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .req       (req)
    );

    vtqr_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .reply_byte (reply_byte),
        .reply_last (reply_last),
        .in_stall   (in_stall)
    );

    // chunk boundaries do not disturb a reply in flight
    a_chunk_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chunk_end && out_valid && !reply_last) |-> 1'b0)
        else $error("transaction accepted while a reply is mid-sequence");

endmodule
